/* rtl/u2a_pkg.sv */
// Shared types and constants for the UTF-8 to ASCII stream decoder.
`timescale 1ns / 1ps

package u2a_pkg;

  localparam int unsigned MaxBufferBytesDef = 65536;

  // Result queue: one pop a cycle, up to two pushes per input request.
  localparam int unsigned RqDepth  = 4;
  localparam int unsigned RqPtrW   = $clog2(RqDepth);
  localparam int unsigned RqCntW   = $clog2(RqDepth + 1);

  // Decoder phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_GATHER = 2'd1;
  localparam logic [1:0] PH_STOP   = 2'd2;

  // Result kinds
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Configuration register indexes (word index)
  localparam logic IDX_OUTPUT_LIMIT = 1'b0;
  localparam logic [15:0] OutputLimitRst = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  due;
    logic [20:0] acc;
    logic [16:0] seen;
    logic [16:0] processed;
    logic [15:0] chars;
    logic        err;
  } u2a_state_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  char_value;
    logic        status;
    logic [16:0] consumed;
    logic [15:0] produced;
    logic        last_of_run;
  } u2a_res_t;

  localparam u2a_state_t StateRst = '{
    phase:     PH_IDLE,
    due:       2'd0,
    acc:       21'd0,
    seen:      17'd0,
    processed: 17'd0,
    chars:     16'd0,
    err:       1'b0
  };

endpackage

/* rtl/utf8_to_ascii_stream_decoder_unit.sv */
// UTF-8 to ASCII stream decoder, top level.
// Path: an accepted byte is held in the input register and decoded when the result queue
//   has room; its results reach m_axis through the queue, char result first, then the buffer status result.
// Throughput: one byte per cycle while results drain at one per cycle; a 4-entry result
//   queue that must have room for two results sets when the input register may advance.
// Reset (rst_ni low, async): empty pipeline and queue, decoder idle, output_limit = 65535.
`timescale 1ns / 1ps

module utf8_to_ascii_stream_decoder_unit import u2a_pkg::*; #(
  parameter int unsigned MAX_BUFFER_BYTES = MaxBufferBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] bytes_left
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [6:0] char_value, [7] status, [24:8] consumed,
                                      // [40:25] produced, [47:41] zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,   // last_of_run
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic [15:0] in_left_q;
  logic        go;
  logic [15:0] limit_q;
  u2a_state_t  state_q, state_nx;
  logic [1:0]  core_push_n;
  logic [1:0]  push_n;
  u2a_res_t    res0, res1, head;
  logic [RqCntW-1:0] q_cnt;
  logic        q_vld;
  logic        cfg_wr;

  // decode only when the queue can take both possible results
  assign go            = in_vld_q && (q_cnt <= RqCntW'(RqDepth - 2));
  assign s_axis_tready = !in_vld_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_left_q <= s_axis_tdata[23:8];
    end
  end

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == IDX_OUTPUT_LIMIT);
  assign prdata = (paddr[2] == IDX_OUTPUT_LIMIT) ? {16'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= OutputLimitRst;
    end else if (cfg_wr) begin
      limit_q <= pwdata[15:0];
    end
  end

  u2a_core #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_core (
    .state_i        (state_q),
    .data_byte_i    (in_byte_q),
    .bytes_left_i   (in_left_q),
    .output_limit_i (limit_q),
    .state_o        (state_nx),
    .push_n_o       (core_push_n),
    .res0_o         (res0),
    .res1_o         (res1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (go) begin
      state_q <= state_nx;
    end
  end

  assign push_n = go ? core_push_n : 2'd0;

  u2a_rfifo u_rq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (res0),
    .push1_i  (res1),
    .pop_i    (m_axis_tready),
    .valid_o  (q_vld),
    .head_o   (head),
    .count_o  (q_cnt)
  );

  assign m_axis_tvalid = q_vld;
  assign m_axis_tdata  = {7'd0, head.produced, head.consumed, head.status, head.char_value};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last_of_run;

  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && in_left_q == 16'd0) |-> (core_push_n != 2'd0))
    else $error("buffer end without status result");

  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && in_left_q == 16'd0) |=> (state_q.seen == 17'd0 && state_q.chars == 16'd0
                                    && state_q.phase == PH_IDLE))
    else $error("buffer state not cleared after status");

  a_chars_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && res0.kind == KIND_CHAR && core_push_n != 2'd0) |-> (state_q.chars < limit_q))
    else $error("character produced past output limit");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(go) |-> $stable(state_q))
    else $error("decoder state moved without a request");

endmodule

/* rtl/u2a_core.sv */
// Per-byte decode step: next decoder state and up to two results.
`timescale 1ns / 1ps

module u2a_core import u2a_pkg::*; #(
  parameter int unsigned MAX_BUFFER_BYTES = MaxBufferBytesDef
) (
  input  u2a_state_t  state_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] bytes_left_i,
  input  logic [15:0] output_limit_i,
  output u2a_state_t  state_o,
  output logic [1:0]  push_n_o,
  output u2a_res_t    res0_o,
  output u2a_res_t    res1_o
);

  localparam int unsigned CapInt = (MAX_BUFFER_BYTES < 32'h1FFFF) ? MAX_BUFFER_BYTES
                                                                   : 32'h1FFFF;
  localparam logic [16:0] CountCap = 17'(CapInt);

  u2a_state_t nst;
  u2a_res_t   char_res;
  u2a_res_t   stat_res;
  logic        char_v;
  logic        stat_v;
  logic        jdo;
  logic [20:0] jcp;
  logic        cont;
  logic [1:0]  lead_due;
  logic        buf_end;

  assign buf_end = (bytes_left_i == 16'd0);

  always_comb begin
    nst      = state_i;
    char_v   = 1'b0;
    jdo      = 1'b0;
    jcp      = state_i.acc;
    lead_due = 2'd0;
    cont     = (data_byte_i[7:6] == 2'b10);

    if (state_i.seen < CountCap) begin
      nst.seen = state_i.seen + 17'd1;
    end

    case (state_i.phase)
      PH_GATHER: begin
        if (cont) begin
          nst.acc = {state_i.acc[14:0], data_byte_i[5:0]};
          nst.due = state_i.due - 2'd1;
        end
        // a bad continuation byte is swallowed and the partial value judged
        jdo = !cont || (nst.due == 2'd0) || buf_end;
        jcp = nst.acc;
      end
      PH_STOP: begin
      end
      default: begin
        if (data_byte_i < 8'h80) begin
          jdo = 1'b1;
          jcp = {13'd0, data_byte_i};
        end else if (data_byte_i < 8'hC0) begin
          nst.phase = PH_STOP;
          nst.err   = 1'b1;
        end else if (data_byte_i < 8'hE0) begin
          nst.acc  = {16'd0, data_byte_i[4:0]};
          lead_due = 2'd1;
        end else if (data_byte_i < 8'hF0) begin
          nst.acc  = {17'd0, data_byte_i[3:0]};
          lead_due = 2'd2;
        end else if (data_byte_i < 8'hF8) begin
          nst.acc  = {18'd0, data_byte_i[2:0]};
          lead_due = 2'd3;
        end else begin
          nst.phase = PH_STOP;
          nst.err   = 1'b1;
        end
        if (lead_due != 2'd0) begin
          // sequence that cannot fit in the rest of the buffer: quiet stop
          if (bytes_left_i < {14'd0, lead_due}) begin
            nst.phase = PH_STOP;
          end else begin
            nst.due   = lead_due;
            nst.phase = PH_GATHER;
          end
        end
      end
    endcase

    if (jdo) begin
      if (jcp < 21'h80) begin
        if (state_i.chars >= output_limit_i) begin
          nst.phase = PH_STOP;
        end else begin
          char_v        = 1'b1;
          nst.chars     = state_i.chars + 16'd1;
          nst.processed = nst.seen;
          nst.phase     = PH_IDLE;
        end
      end else begin
        nst.phase = PH_STOP;
        nst.err   = 1'b1;
      end
    end
  end

  assign stat_v = buf_end;

  always_comb begin
    char_res             = '0;
    char_res.kind        = KIND_CHAR;
    char_res.char_value  = jcp[6:0];
    char_res.last_of_run = !stat_v;

    stat_res             = '0;
    stat_res.kind        = KIND_STATUS;
    stat_res.status      = nst.err;
    stat_res.consumed    = nst.processed;
    stat_res.produced    = nst.chars;
    stat_res.last_of_run = 1'b1;
  end

  assign state_o  = stat_v ? StateRst : nst;
  assign push_n_o = {1'b0, char_v} + {1'b0, stat_v};
  assign res0_o   = char_v ? char_res : stat_res;
  assign res1_o   = stat_res;

endmodule

/* rtl/u2a_rfifo.sv */
// Small result queue taking up to two results per cycle, draining one.
`timescale 1ns / 1ps

module u2a_rfifo import u2a_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  push_n_i,
  input  u2a_res_t    push0_i,
  input  u2a_res_t    push1_i,
  input  logic        pop_i,
  output logic        valid_o,
  output u2a_res_t    head_o,
  output logic [RqCntW-1:0] count_o
);

  u2a_res_t            mem_q [RqDepth];
  logic [RqPtrW-1:0]   wr_q, wr_d;
  logic [RqPtrW-1:0]   rd_q, rd_d;
  logic [RqCntW-1:0]   cnt_q, cnt_d;
  logic [RqPtrW-1:0]   wr_nx;
  logic                pop_ok;

  assign pop_ok = pop_i && (cnt_q != '0);
  assign wr_nx  = wr_q + RqPtrW'(1);
  assign wr_d   = wr_q + RqPtrW'(push_n_i);
  assign rd_d   = pop_ok ? rd_q + RqPtrW'(1) : rd_q;
  assign cnt_d  = cnt_q + RqCntW'(push_n_i) - RqCntW'(pop_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nx] <= push1_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RqCntW'(RqDepth))
    else $error("result queue overflow");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == RqCntW'(RqDepth)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");

  a_pop_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && cnt_q != '0) |=> (rd_q == $past(rd_q) + RqPtrW'(1)))
    else $error("read pointer did not advance on pop");

endmodule

/* verif/utf8_decode_checker.sv */
// Scoreboard for the UTF-8 to ASCII decoder: tracks decode state from accepted requests and checks results.
`timescale 1ns / 1ps

module utf8_decode_checker import u2a_pkg::*; #(
  parameter int unsigned MAX_BUFFER_BYTES = MaxBufferBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] bytes_left
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [6:0] char_value, [7] status, [24:8] consumed,
                                      // [40:25] produced, [47:41] zero
  input  logic        m_axis_tuser,   // [0] kind
  input  logic        m_axis_tlast,   // last_of_run
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned CountCapI  = (MAX_BUFFER_BYTES < 'h1FFFF) ? MAX_BUFFER_BYTES : 'h1FFFF;
  localparam logic [16:0] CountCap   = CountCapI[16:0];
  localparam int unsigned MaxReports = 100;

  // mirror of the decoder state
  logic [1:0]  phase;
  logic [1:0]  due_cnt;
  logic [20:0] code_acc;
  logic [16:0] seen_cnt;
  logic [16:0] done_cnt;
  logic [15:0] char_cnt;
  logic        err_flag;
  logic [15:0] out_limit;

  u2a_res_t    expected_q[$];
  u2a_res_t    step_q[$];
  int unsigned results_seen;

  function automatic u2a_res_t make_res(logic kind, logic [6:0] ch, logic st,
                                        logic [16:0] cons, logic [15:0] prod);
    u2a_res_t r;
    r.kind        = kind;
    r.char_value  = ch;
    r.status      = st;
    r.consumed    = cons;
    r.produced    = prod;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_count_o++;
    if (fail_count_o <= MaxReports)
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h (result #%0d)",
               $realtime, what, got, want, results_seen);
  endtask

  task automatic clear_buffer();
    phase    = PH_IDLE;
    due_cnt  = 2'd0;
    code_acc = 21'd0;
    seen_cnt = 17'd0;
    done_cnt = 17'd0;
    char_cnt = 16'd0;
    err_flag = 1'b0;
  endtask

  task automatic halt_on_error();
    phase    = PH_STOP;
    err_flag = 1'b1;
  endtask

  // A finished or cut-short code point: ASCII goes out unless the output area is full.
  task automatic judge_code(input logic [20:0] cp);
    if (cp < 21'h80) begin
      if (char_cnt >= out_limit) begin
        phase = PH_STOP;
      end else begin
        step_q.push_back(make_res(KIND_CHAR, cp[6:0], 1'b0, 17'd0, 16'd0));
        char_cnt = char_cnt + 16'd1;
        done_cnt = seen_cnt;
        phase    = PH_IDLE;
      end
    end else begin
      halt_on_error();
    end
  endtask

  task automatic decode_byte(input logic [7:0] d, input logic [15:0] left);
    logic [1:0] need;
    need = 2'd0;
    step_q.delete();
    if (seen_cnt < CountCap) seen_cnt = seen_cnt + 17'd1;

    if (phase == PH_GATHER) begin
      if (d[7:6] != 2'b10) begin
        // bad continuation: byte is swallowed, partial value judged
        judge_code(code_acc);
      end else begin
        code_acc = {code_acc[14:0], d[5:0]};
        due_cnt  = due_cnt - 2'd1;
        if (due_cnt == 2'd0) judge_code(code_acc);
      end
      if (phase == PH_GATHER && left == 16'd0) judge_code(code_acc);
    end else if (phase != PH_STOP) begin
      if (d < 8'h80) begin
        judge_code({13'd0, d});
      end else if (d < 8'hC0) begin
        halt_on_error();
      end else if (d < 8'hE0) begin
        code_acc = {16'd0, d[4:0]};
        need     = 2'd1;
      end else if (d < 8'hF0) begin
        code_acc = {17'd0, d[3:0]};
        need     = 2'd2;
      end else if (d < 8'hF8) begin
        code_acc = {18'd0, d[2:0]};
        need     = 2'd3;
      end else begin
        halt_on_error();
      end
      if (need != 2'd0) begin
        if (left < 16'(need)) begin
          phase = PH_STOP;
        end else begin
          due_cnt = need;
          phase   = PH_GATHER;
        end
      end
    end

    if (left == 16'd0) begin
      step_q.push_back(make_res(KIND_STATUS, 7'd0, err_flag, done_cnt, char_cnt));
      clear_buffer();
    end

    if (step_q.size() > 0) step_q[step_q.size() - 1].last_of_run = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track_proc
    u2a_res_t want;
    if (!rst_ni) begin
      clear_buffer();
      out_limit = OutputLimitRst;
      expected_q.delete();
      results_seen = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == IDX_OUTPUT_LIMIT)
        out_limit = pwdata[15:0];

      if (s_axis_tvalid && s_axis_tready)
        decode_byte(s_axis_tdata[7:0], s_axis_tdata[23:8]);

      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing pending, tdata", m_axis_tdata, 0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tuser != want.kind)
            report_mismatch("kind", m_axis_tuser, want.kind);
          if (m_axis_tdata[6:0] != want.char_value)
            report_mismatch("char_value", m_axis_tdata[6:0], want.char_value);
          if (m_axis_tdata[7] != want.status)
            report_mismatch("status", m_axis_tdata[7], want.status);
          if (m_axis_tdata[24:8] != want.consumed)
            report_mismatch("consumed", m_axis_tdata[24:8], want.consumed);
          if (m_axis_tdata[40:25] != want.produced)
            report_mismatch("produced", m_axis_tdata[40:25], want.produced);
          if (m_axis_tlast != want.last_of_run)
            report_mismatch("last_of_run", m_axis_tlast, want.last_of_run);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the UTF-8 to ASCII decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench import u2a_pkg::*; ();

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomBytes = 1700;
  localparam int unsigned LongBytes   = 300;    // 3-byte sequences, back to back

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // [7:0] data_byte, [23:8] bytes_left
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [47:0] m_axis_tdata;         // [6:0] char_value, [7] status, [24:8] consumed,
                                     // [40:25] produced, [47:41] zero
  logic        m_axis_tuser;         // [0] kind
  logic        m_axis_tlast;         // last_of_run
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  bit          idle_on = 1'b1;
  int unsigned cycle_cnt = 0;
  int unsigned rdy_hold = 0;
  int unsigned bytes_sent = 0;
  int unsigned buffers_sent = 0;
  int unsigned limit_writes = 0;
  logic [7:0]  frame_q[$];

  utf8_to_ascii_stream_decoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  utf8_decode_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("utf8_to_ascii_stream_decoder_unit verification failed");
      $finish;
    end
  end

  // Result side back-pressure in bursts.
  always @(posedge clk_i) begin
    if (rdy_hold != 0) begin
      rdy_hold = rdy_hold - 1;
      if (rdy_hold == 0) m_axis_tready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rdy_hold = $urandom_range(1, 7);
      m_axis_tready <= 1'b0;
    end
  end

  task automatic send_req(input logic [7:0] data_byte, input logic [15:0] bytes_left);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bytes_left, data_byte};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  // Hold off the sender until every pending result is out and the pipe is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {IDX_OUTPUT_LIMIT, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    limit_writes++;
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  // Mostly well-formed sequences (ASCII and overlong forms of ASCII), some malformed ones.
  task automatic build_frame();
    int         n_seq;
    int         pick;
    logic [6:0] v;
    logic [7:0] lead;
    frame_q.delete();
    n_seq = $urandom_range(1, 6);
    repeat (n_seq) begin
      v    = 7'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        frame_q.push_back({1'b0, v});
      end else if (pick < 55) begin
        frame_q.push_back({7'b1100000, v[6]});
        frame_q.push_back({2'b10, v[5:0]});
      end else if (pick < 64) begin
        frame_q.push_back(8'hE0);
        frame_q.push_back({7'b1000000, v[6]});
        frame_q.push_back({2'b10, v[5:0]});
      end else if (pick < 70) begin
        frame_q.push_back(8'hF0);
        frame_q.push_back(8'h80);
        frame_q.push_back({7'b1000000, v[6]});
        frame_q.push_back({2'b10, v[5:0]});
      end else if (pick < 76) begin
        // complete sequence with random payload, usually beyond ASCII
        lead = 8'($urandom_range(8'hC2, 8'hF7));
        frame_q.push_back(lead);
        repeat (lead >= 8'hF0 ? 3 : (lead >= 8'hE0 ? 2 : 1))
          frame_q.push_back({2'b10, 6'($urandom)});
      end else if (pick < 81) begin
        frame_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 85) begin
        frame_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end else if (pick < 92) begin
        // lead cut short by a byte that is not a continuation
        frame_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
        lead = 8'($urandom);
        if (lead[7:6] == 2'b10) lead[6] = 1'b1;
        frame_q.push_back(lead);
      end else if (pick < 96) begin
        frame_q.push_back(8'($urandom_range(8'hE0, 8'hF7)));
        frame_q.push_back({2'b10, 6'($urandom)});
      end else begin
        frame_q.push_back(8'($urandom));
      end
    end
  endtask

  task automatic send_frame(input bit noisy);
    int unsigned last_idx;
    logic [15:0] left;
    last_idx = frame_q.size() - 1;
    for (int i = 0; i <= int'(last_idx); i++) begin
      left = 16'(last_idx - i);
      if (noisy && i != int'(last_idx) && $urandom_range(0, 39) == 0) left = 16'($urandom);
      if (noisy && $urandom_range(0, 199) == 0) begin
        settle();
        write_limit(pick_limit());
      end
      send_req(frame_q[i], left);
    end
    buffers_sent++;
  endtask

  initial begin
    int unsigned remain;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ASCII extremes, overlong forms, each error and quiet stop
    write_limit(16'hFFFF);
    frame_q = '{8'h00, 8'h7F, 8'hC1, 8'h81};
    send_frame(1'b0);
    frame_q = '{8'hE0, 8'h81, 8'h81, 8'hF0, 8'h80, 8'h80, 8'hBF};
    send_frame(1'b0);
    frame_q = '{8'h80, 8'h41};            // stray continuation, rest ignored
    send_frame(1'b0);
    frame_q = '{8'hFF};
    send_frame(1'b0);
    frame_q = '{8'hC2, 8'h80};            // code point 0x80
    send_frame(1'b0);
    frame_q = '{8'hE2, 8'h82};            // sequence does not fit
    send_frame(1'b0);
    frame_q = '{8'hC1, 8'h41, 8'h42};     // bad continuation
    send_frame(1'b0);
    send_req(8'hE1, 16'hFFFF);            // buffer ends mid-sequence
    send_req(8'h80, 16'h0000);
    settle();
    write_limit(16'd0);
    frame_q = '{8'h41};
    send_frame(1'b0);
    settle();
    write_limit(16'd1);
    send_req(8'h41, 16'd2);
    settle();
    write_limit(16'd2);                   // limit raised mid-buffer
    send_req(8'h42, 16'd1);
    send_req(8'h43, 16'd0);

    settle();
    write_limit(16'hFFFF);
    while (bytes_sent < RandomBytes) begin
      if (buffers_sent % 16 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 24) == 0) begin
        settle();
        write_limit(pick_limit());
      end
      build_frame();
      send_frame(1'b1);
    end

    // final stretch without idling: one long buffer sent back to back
    idle_on = 1'b0;
    settle();
    write_limit(16'hFFFF);
    for (int k = 0; k < int'(LongBytes); k++) begin
      remain = LongBytes - 1 - k;
      send_req((k % 3 == 0) ? 8'hE0 : 8'h81, 16'(remain));
    end
    buffers_sent++;

    settle();
    $display("sent %0d bytes in %0d buffers with %0d limit writes", bytes_sent,
             buffers_sent, limit_writes);
    $display("covered overlong forms, malformed input, full output areas and a long buffer");
    if (fail_count == 0 && pending == 0) begin
      $display("utf8_to_ascii_stream_decoder_unit verification clean");
    end else begin
      $display("utf8_to_ascii_stream_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
